>>> rtl/bfu_pkg.sv
// Package: shared types and constants for the binary field unpacker.
package bfu_pkg;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_SETPOS = 2'd2;
   localparam logic [1:0] REQ_UNPACK = 2'd3;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_SHORT  = 3'd1;
   localparam logic [2:0] ST_LEB    = 3'd2;
   localparam logic [2:0] ST_EMPTY  = 3'd3;
   localparam logic [2:0] ST_RANGE  = 3'd4;

   localparam logic [4:0] K_U8      = 5'd0;
   localparam logic [4:0] K_S8      = 5'd1;
   localparam logic [4:0] K_BOOL    = 5'd2;
   localparam logic [4:0] K_ULEB    = 5'd15;
   localparam logic [4:0] K_SLEB    = 5'd16;
   localparam logic [4:0] K_STR     = 5'd17;
   localparam logic [4:0] K_BLK     = 5'd18;
   localparam logic [4:0] K_BLK_U8  = 5'd19;
   localparam logic [4:0] K_BLK_LEB = 5'd26;

   localparam logic [7:0] LEB_MASK  = 8'h7f;

   // how a fixed-width or prefixed kind reads its bytes
   typedef struct packed {
      logic [3:0] nbytes;   // 0: not a fixed read
      logic       big;
      logic       sgn;
      logic       blk;      // fixed prefix followed by a block
   } fix_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_START = 7'b0000010,
      S_FIX   = 7'b0000100,
      S_LEB   = 7'b0001000,
      S_STR   = 7'b0010000,
      S_BLOCK = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   function automatic fix_type fix_decode(input logic [4:0] k);
      fix_type f;
      logic [4:0] idx;
      logic [2:0] sub;
      f = '0;
      idx = 5'd0;
      sub = 3'd0;
      if (k <= K_BOOL) begin
         f.nbytes = 4'd1;
         f.big = 1'b1;
         f.sgn = (k == K_S8);
      end else if (k <= 5'd14) begin
         idx = k - 5'd3;
         sub = (idx >= 5'd6) ? 3'(idx - 5'd6) : idx[2:0];
         f.big = (idx < 5'd6);
         f.sgn = sub[0];
         case (sub[2:1])
            2'd0:    f.nbytes = 4'd2;
            2'd1:    f.nbytes = 4'd4;
            default: f.nbytes = 4'd8;
         endcase
      end else if (k == K_BLK_U8) begin
         f.nbytes = 4'd1;
         f.big = 1'b1;
         f.blk = 1'b1;
      end else if (k >= 5'd20 && k <= 5'd25) begin
         idx = k - 5'd20;
         sub = (idx >= 5'd3) ? 3'(idx - 5'd3) : idx[2:0];
         f.big = (idx < 5'd3);
         f.blk = 1'b1;
         case (sub[1:0])
            2'd0:    f.nbytes = 4'd2;
            2'd1:    f.nbytes = 4'd4;
            default: f.nbytes = 4'd8;
         endcase
      end
      return f;
   endfunction

endpackage

>>> rtl/bfu_ram.sv
// Generic single-port RAM with registered read.
module bfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule

>>> rtl/binary_field_unpacker.sv
// Top level: byte buffer with sequencer that unpacks fields one byte per cycle.
// Clear, append and set-position pass from accept through S_START to S_DONE.
// Fixed fields, LEB128 and strings read their bytes in S_FIX, S_LEB or S_STR;
// blocks add S_BLOCK. One byte read from the buffer RAM per cycle sets the rate.
// One request at a time; a new one is taken once the result beat has gone.
// Reset clears length, position and control; the buffer contents are left as they are.
module binary_field_unpacker
   import bfu_pkg::*;
#(
   parameter int BUF_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_data_byte,
   input  logic [12:0] req_new_pos,
   input  logic [4:0]  req_field_kind,
   input  logic [12:0] req_explicit_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value_bits,
   output logic        rsp_value_is_signed,
   output logic [12:0] rsp_span_start,
   output logic [12:0] rsp_span_length,
   output logic [2:0]  rsp_status,
   output logic [12:0] rsp_pos_after
);

   localparam int AW = $clog2(BUF_BYTES);
   localparam int LW = $clog2(BUF_BYTES + 1);
   localparam logic [LW-1:0] FULL = LW'(BUF_BYTES);

   state_type        state_ff, state_in;
   logic [LW-1:0]    len_ff, len_in;
   logic [LW-1:0]    pos_ff, pos_in;
   logic [LW-1:0]    cur_ff, cur_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [6:0]       shift_ff, shift_in;
   logic [1:0]       rt_ff, rt_in;
   logic [7:0]       byte_ff, byte_in;
   logic [12:0]      npos_ff, npos_in;
   logic [4:0]       kind_ff, kind_in;
   logic [12:0]      elen_ff, elen_in;
   fix_type          fix_ff, fix_in;
   logic [63:0]      acc_ff, acc_in;
   logic             sgn_ff, sgn_in;
   logic [LW-1:0]    start_ff, start_in;
   logic [LW-1:0]    slen_ff, slen_in;
   logic [2:0]       stat_ff, stat_in;
   logic [LW-1:0]    rem;

   logic             ram_we;
   logic [AW-1:0]    ram_addr;
   logic [7:0]       ram_q;

   bfu_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (byte_ff),
      .rd_data (ram_q)
   );

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = (state_ff == S_DONE);
   assign rsp_value_bits      = acc_ff;
   assign rsp_value_is_signed = sgn_ff;
   assign rsp_span_start      = 13'(start_ff);
   assign rsp_span_length     = 13'(slen_ff);
   assign rsp_status          = stat_ff;
   assign rsp_pos_after       = 13'(pos_ff);
   assign rem                 = len_ff - pos_ff;

   always_comb begin
      state_in = state_ff;
      len_in = len_ff; pos_in = pos_ff; cur_in = cur_ff; cnt_in = cnt_ff;
      shift_in = shift_ff; rt_in = rt_ff; byte_in = byte_ff; npos_in = npos_ff;
      kind_in = kind_ff; elen_in = elen_ff; fix_in = fix_ff; acc_in = acc_ff;
      sgn_in = sgn_ff; start_in = start_ff; slen_in = slen_ff; stat_in = stat_ff;
      ram_we = 1'b0;
      ram_addr = cur_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rt_in = req_type; byte_in = req_data_byte; npos_in = req_new_pos;
               kind_in = req_field_kind; elen_in = req_explicit_length;
               fix_in = fix_decode(req_field_kind);
               state_in = S_START;
            end
         end
         S_START: begin
            acc_in = '0; sgn_in = 1'b0; start_in = '0; slen_in = '0; stat_in = ST_OK;
            cur_in = pos_ff; cnt_in = '0; shift_in = '0;
            state_in = S_DONE;
            case (rt_ff)
               REQ_CLEAR: begin
                  len_in = '0; pos_in = '0;
               end
               REQ_APPEND: begin
                  if (len_ff < FULL) begin
                     ram_we = 1'b1;
                     ram_addr = len_ff[AW-1:0];
                     len_in = len_ff + 1'b1;
                  end else begin
                     stat_in = ST_SHORT;
                  end
               end
               REQ_SETPOS: begin
                  if ({3'b0, npos_ff} > (LW + 3)'(len_ff)) stat_in = ST_RANGE;
                  else pos_in = LW'(npos_ff);
               end
               default: begin
                  // first byte read issued here, lands in the next state
                  ram_addr = pos_ff[AW-1:0];
                  if (fix_ff.nbytes != 4'd0) begin
                     if (rem < LW'(fix_ff.nbytes)) stat_in = ST_SHORT;
                     else begin
                        state_in = S_FIX;
                        cur_in = pos_ff + 1'b1;
                     end
                  end else if (kind_ff == K_ULEB || kind_ff == K_SLEB
                               || kind_ff == K_BLK_LEB) begin
                     if (rem == '0) stat_in = ST_LEB;
                     else begin
                        state_in = S_LEB; cur_in = pos_ff + 1'b1;
                     end
                  end else if (kind_ff == K_STR) begin
                     if (rem == '0) stat_in = ST_EMPTY;
                     else begin
                        state_in = S_STR; cur_in = pos_ff + 1'b1;
                     end
                  end else if (kind_ff == K_BLK) begin
                     acc_in = 64'(elen_ff);
                     state_in = S_BLOCK;
                  end
               end
            endcase
         end
         S_FIX: begin
            if (fix_ff.big) acc_in = {acc_ff[55:0], ram_q};
            else acc_in = acc_ff | (64'(ram_q) << {cnt_ff[2:0], 3'b000});
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff + 1'b1 == fix_ff.nbytes) begin
               pos_in = pos_ff + LW'(fix_ff.nbytes);
               state_in = fix_ff.blk ? S_BLOCK : S_DONE;
               if (fix_ff.sgn) begin
                  sgn_in = 1'b1;
                  case (fix_ff.nbytes)
                     4'd1:    acc_in = {{56{acc_in[7]}}, acc_in[7:0]};
                     4'd2:    acc_in = {{48{acc_in[15]}}, acc_in[15:0]};
                     4'd4:    acc_in = {{32{acc_in[31]}}, acc_in[31:0]};
                     default: ;
                  endcase
               end else if (kind_ff == K_BOOL) begin
                  acc_in = {63'b0, acc_in != 64'd0};
               end
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         S_LEB: begin
            if (shift_ff < 7'd64)
               acc_in = acc_ff | (64'(ram_q & LEB_MASK) << shift_ff[5:0]);
            if (shift_ff < 7'd70) shift_in = shift_ff + 7'd7;
            if (!ram_q[7]) begin
               pos_in = cur_ff;
               if (kind_ff == K_SLEB) begin
                  sgn_in = 1'b1;
                  if (ram_q[6] && shift_in < 7'd64)
                     acc_in = acc_in | (~64'd0 << shift_in[5:0]);
               end
               state_in = (kind_ff == K_BLK_LEB) ? S_BLOCK : S_DONE;
            end else if (cur_ff >= len_ff) begin
               acc_in = '0; stat_in = ST_LEB; state_in = S_DONE;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         S_STR: begin
            start_in = pos_ff;
            if (ram_q == 8'd0) begin
               slen_in = cur_ff - pos_ff - 1'b1;
               pos_in = cur_ff; state_in = S_DONE;
            end else if (cur_ff >= len_ff) begin
               slen_in = len_ff - pos_ff;
               pos_in = len_ff; state_in = S_DONE;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         S_BLOCK: begin
            state_in = S_DONE;
            if (acc_ff > 64'(rem)) stat_in = ST_SHORT;
            else begin
               start_in = pos_ff;
               slen_in = LW'(acc_ff);
               pos_in = pos_ff + LW'(acc_ff);
            end
            acc_in = '0;
         end
         S_DONE: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff <= '0;
         pos_ff <= '0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in; cnt_ff <= cnt_in; shift_ff <= shift_in; rt_ff <= rt_in;
      byte_ff <= byte_in; npos_ff <= npos_in; kind_ff <= kind_in; elen_ff <= elen_in;
      fix_ff <= fix_in; acc_ff <= acc_in; sgn_ff <= sgn_in; start_ff <= start_in;
      slen_ff <= slen_in; stat_ff <= stat_in;
   end

endmodule

>>> sim/testbench.sv
// Testbench for binary_field_unpacker: random request beats checked against an in-bench predictor.
`timescale 1ns / 100ps

module testbench;
   import bfu_pkg::*;

   localparam int DEPTH = 4096;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [63:0] value_bits;
      logic        value_is_signed;
      logic [12:0] span_start;
      logic [12:0] span_length;
      logic [2:0]  status;
      logic [12:0] pos_after;
   } field_result_type;

   class unpack_tracker;
      logic [7:0]       mem [DEPTH];
      int unsigned      fill;
      int unsigned      rpos;
      field_result_type awaited [$];
      int               errors;
      field_result_type r;

      function new();
         fill = 0;
         rpos = 0;
         errors = 0;
      endfunction

      function int unsigned left();
         return (rpos <= fill) ? fill - rpos : 0;
      endfunction

      function bit take_fixed(int unsigned n, bit big, output logic [63:0] v);
         logic [63:0] acc;
         acc = '0;
         v = '0;
         if (left() < n) return 0;
         for (int i = 0; i < n; i++) begin
            if (big) acc = (acc << 8) | 64'(mem[rpos + i]);
            else acc |= 64'(mem[rpos + i]) << (8 * i);
         end
         rpos += n;
         v = acc;
         return 1;
      endfunction

      function logic [63:0] sext(logic [63:0] v, int bits);
         if (bits < 64 && v[bits - 1]) v |= ~64'd0 << bits;
         return v;
      endfunction

      function bit take_leb(bit sgn, output logic [63:0] v);
         int unsigned saved, shift;
         logic [63:0] acc;
         logic [7:0]  b;
         saved = rpos;
         shift = 0;
         acc = '0;
         v = '0;
         while (rpos < fill) begin
            b = mem[rpos];
            rpos++;
            if (shift < 64) acc |= 64'(b & LEB_MASK) << shift;
            shift += 7;
            if (b < 8'd128) begin
               if (sgn && b >= 8'd64 && shift < 64) acc |= ~64'd0 << shift;
               v = acc;
               return 1;
            end
         end
         rpos = saved;
         return 0;
      endfunction

      function void give_block(logic [63:0] blen);
         if (blen > 64'(left())) begin
            r.status = ST_SHORT;
            return;
         end
         r.span_start = 13'(rpos);
         r.span_length = 13'(blen);
         rpos += int'(blen);
      endfunction

      function void unpack(logic [4:0] kind, logic [12:0] elen);
         logic [63:0] v;
         int unsigned idx, sub, n, rem;
         if (kind <= K_BOOL) begin
            if (!take_fixed(1, 1, v)) begin r.status = ST_SHORT; return; end
            if (kind == K_S8) begin
               r.value_bits = sext(v, 8);
               r.value_is_signed = 1'b1;
            end else if (kind == K_BOOL) r.value_bits = (v != 0) ? 64'd1 : 64'd0;
            else r.value_bits = v;
         end else if (kind <= 5'd14) begin
            idx = kind - 3;
            sub = idx % 6;
            n = 2 << (sub / 2);
            if (!take_fixed(n, idx < 6, v)) begin r.status = ST_SHORT; return; end
            if (sub & 1) begin
               r.value_bits = sext(v, n * 8);
               r.value_is_signed = 1'b1;
            end else r.value_bits = v;
         end else if (kind <= K_SLEB) begin
            if (!take_leb(kind == K_SLEB, v)) begin r.status = ST_LEB; return; end
            r.value_bits = v;
            r.value_is_signed = (kind == K_SLEB);
         end else if (kind == K_STR) begin
            rem = left();
            n = 0;
            if (rem == 0) begin r.status = ST_EMPTY; return; end
            while (n < rem && mem[rpos + n] != 8'd0) n++;
            r.span_start = 13'(rpos);
            r.span_length = 13'(n);
            rpos += (n < rem) ? n + 1 : rem;
         end else if (kind == K_BLK) begin
            give_block(64'(elen));
         end else if (kind == K_BLK_U8) begin
            if (!take_fixed(1, 1, v)) begin r.status = ST_SHORT; return; end
            give_block(v);
         end else if (kind <= 5'd25) begin
            idx = kind - 20;
            if (!take_fixed(2 << (idx % 3), idx < 3, v)) begin
               r.status = ST_SHORT;
               return;
            end
            give_block(v);
         end else if (kind == K_BLK_LEB) begin
            if (!take_leb(0, v)) begin r.status = ST_LEB; return; end
            give_block(v);
         end
      endfunction

      function void note_request(logic [1:0] t, logic [7:0] db, logic [12:0] np,
                                 logic [4:0] kind, logic [12:0] elen);
         r = '{default: '0};
         case (t)
            REQ_CLEAR: begin
               fill = 0;
               rpos = 0;
            end
            REQ_APPEND: begin
               if (fill < DEPTH) begin
                  mem[fill] = db;
                  fill++;
               end else r.status = ST_SHORT;
            end
            REQ_SETPOS: begin
               if (np > fill) r.status = ST_RANGE;
               else rpos = np;
            end
            default: unpack(kind, elen);
         endcase
         r.pos_after = 13'(rpos);
         awaited.push_back(r);
      endfunction

      function void check_response(field_result_type got);
         field_result_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10) $display("response beat with nothing awaited");
            return;
         end
         want = awaited.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: want v=%h s=%b st=%0d len=%0d status=%0d pos=%0d",
                        want.value_bits, want.value_is_signed, want.span_start,
                        want.span_length, want.status, want.pos_after);
               $display("          got  v=%h s=%b st=%0d len=%0d status=%0d pos=%0d",
                        got.value_bits, got.value_is_signed, got.span_start,
                        got.span_length, got.status, got.pos_after);
            end
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_type = '0;
   logic [7:0]  req_data_byte = '0;
   logic [12:0] req_new_pos = '0;
   logic [4:0]  req_field_kind = '0;
   logic [12:0] req_explicit_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [63:0] rsp_value_bits;
   logic        rsp_value_is_signed;
   logic [12:0] rsp_span_start;
   logic [12:0] rsp_span_length;
   logic [2:0]  rsp_status;
   logic [12:0] rsp_pos_after;

   unpack_tracker tracker = new();
   bit calm = 0;
   bit want_hold = 0;
   int sent = 0;
   int quiet_cycles = 0;

   binary_field_unpacker dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("binary_field_unpacker regression: fail");
         $finish;
      end
   end

   // receiver: random back-pressure, one long hold-off on request
   initial begin
      int hold;
      field_result_type got;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.value_bits = rsp_value_bits;
            got.value_is_signed = rsp_value_is_signed;
            got.span_start = rsp_span_start;
            got.span_length = rsp_span_length;
            got.status = rsp_status;
            got.pos_after = rsp_pos_after;
            tracker.check_response(got);
         end
         @(negedge clock);
         if (want_hold && hold == 0) begin
            want_hold = 0;
            hold = 300;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 0;
         end else rsp_ready <= calm || ($urandom_range(99) >= 16);
      end
   end

   task automatic send(logic [1:0] t, logic [7:0] db, logic [12:0] np,
                       logic [4:0] kind, logic [12:0] elen);
      while (!calm && $urandom_range(99) < 16) begin
         @(negedge clock);
         req_valid <= 0;
         @(posedge clock);
      end
      @(negedge clock);
      req_valid <= 1;
      req_type <= t;
      req_data_byte <= db;
      req_new_pos <= np;
      req_field_kind <= kind;
      req_explicit_length <= elen;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(t, db, np, kind, elen);
      sent++;
   endtask

   task automatic push_byte(logic [7:0] b);
      send(REQ_APPEND, b, 13'($urandom), 5'($urandom), 13'($urandom));
   endtask

   task automatic do_unpack(logic [4:0] kind, logic [12:0] elen);
      send(REQ_UNPACK, 8'($urandom), 13'($urandom), kind, elen);
   endtask

   task automatic do_setpos(logic [12:0] np);
      send(REQ_SETPOS, 8'($urandom), np, 5'($urandom), 13'($urandom));
   endtask

   function automatic logic [7:0] pick_byte();
      int c;
      c = $urandom_range(99);
      if (c < 30) return 8'd0;
      if (c < 50) return 8'($urandom_range(1, 8));
      if (c < 65) return 8'h80 | 8'($urandom);
      if (c < 80) return 8'($urandom_range(64, 127));
      return 8'($urandom);
   endfunction

   initial begin
      int n, m, c;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: empty buffer, range error, incomplete and long LEB128, unterminated string
      send(REQ_CLEAR, 8'h00, 13'd0, 5'd0, 13'd0);
      do_unpack(K_U8, 13'd0);
      do_unpack(K_STR, 13'd0);
      do_unpack(K_BLK, 13'd0);
      do_setpos(13'd1);
      do_setpos(13'h1fff);
      push_byte(8'h80);
      push_byte(8'hff);
      do_unpack(K_ULEB, 13'd0);
      do_unpack(K_SLEB, 13'd0);
      do_unpack(K_BLK_LEB, 13'd0);
      for (int i = 0; i < 9; i++) push_byte(8'hff);
      push_byte(8'h7f);
      do_unpack(K_SLEB, 13'd0);
      do_setpos(13'd0);
      do_unpack(K_ULEB, 13'd0);
      do_setpos(13'd0);
      do_unpack(5'd8, 13'd0);
      do_unpack(K_S8, 13'd0);
      do_unpack(K_BOOL, 13'd0);
      do_unpack(K_STR, 13'd0);
      do_unpack(K_STR, 13'd0);
      do_unpack(5'd31, 13'h1fff);

      while (sent < 1750) begin
         calm = (sent > 1000 && sent < 1300);
         if (sent > 300 && sent < 320) want_hold = 1;
         send(REQ_CLEAR, 8'($urandom), 13'($urandom), 5'($urandom), 13'($urandom));
         n = ($urandom_range(9) == 0) ? $urandom_range(25, 70) : $urandom_range(0, 24);
         for (int i = 0; i < n; i++) push_byte(pick_byte());
         m = $urandom_range(1, 10);
         for (int i = 0; i < m; i++) begin
            c = $urandom_range(99);
            if (c < 70)
               do_unpack(5'($urandom_range(0, 31)),
                         ($urandom_range(9) == 0) ? 13'($urandom)
                                                  : 13'($urandom_range(0, n + 2)));
            else if (c < 88)
               do_setpos(($urandom_range(9) == 0) ? 13'($urandom)
                                                  : 13'($urandom_range(0, n + 1)));
            else
               send(2'($urandom), 8'($urandom), 13'($urandom), 5'($urandom), 13'($urandom));
         end
      end
      calm = 0;
      @(negedge clock);
      req_valid <= 0;
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.errors == 0) $display("binary_field_unpacker regression: pass");
      else $display("binary_field_unpacker regression: fail");
      $finish;
   end

endmodule

>>> filelist.f
rtl/bfu_pkg.sv
rtl/bfu_ram.sv
rtl/binary_field_unpacker.sv
sim/testbench.sv
